FILE: hdl/bfa_pkg.sv
// Package for the block fit allocator: function and outcome codes,
// controller states and the records passed between the table cells.
// No dependencies.
package bfa_pkg;

   // Function codes carried in the request tuser
   typedef enum logic [1:0] {
      FUNC_APPEND = 2'd0,
      FUNC_FIRST  = 2'd1,
      FUNC_BEST   = 2'd2,
      FUNC_WORST  = 2'd3
   } func_type;

   // Outcome codes carried in the response tuser
   localparam logic [1:0] OUT_OK    = 2'd0;
   localparam logic [1:0] OUT_NOFIT = 2'd1;
   localparam logic [1:0] OUT_FULL  = 2'd2;

   localparam int SIZE_W  = 16;
   localparam int PID_W   = 16;
   localparam int FUNC_W  = 2;
   localparam int OUT_W   = 2;
   localparam int IDXO_W  = 4;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Search record handed from cell to cell, one hop per cycle
   typedef struct packed {
      logic              active;
      logic              found;
      func_type          func;
      logic [SIZE_W-1:0] req_size;
      logic [SIZE_W-1:0] pick_size;
   } search_type;

   // Table write broadcast to all cells
   typedef struct packed {
      logic              load;    // append: write a whole entry
      logic              claim;   // grant: clear free mark, set owner
      logic [SIZE_W-1:0] size;
      logic              free;
      logic [PID_W-1:0]  owner;
   } tbl_wr_type;

endpackage

FILE: hdl/bfa_cell.sv
// One table cell of the block fit allocator: holds one block entry and
// updates the search record passing through it. Depends on bfa_pkg.
module bfa_cell #(
   parameter int IDX_W = 4,
   parameter int CNT_W = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [IDX_W-1:0]    cell_index,
   input  logic [CNT_W-1:0]    blocks_in_use,
   input  bfa_pkg::tbl_wr_type wr,
   input  logic [IDX_W-1:0]    wr_index,
   input  bfa_pkg::search_type srch_in,
   input  logic [IDX_W-1:0]    pick_in,
   output bfa_pkg::search_type srch_out,
   output logic [IDX_W-1:0]    pick_out
);
   import bfa_pkg::*;

   logic [SIZE_W-1:0] size_ff;
   logic              free_ff;
   logic [PID_W-1:0]  owner_ff;
   search_type        srch_ff;
   search_type        srch_in_n;
   logic [IDX_W-1:0]  pick_ff;
   logic [IDX_W-1:0]  pick_in_n;
   logic              in_use;
   logic              eligible;
   logic              take;
   logic              wr_hit;

   assign in_use   = {{(CNT_W-IDX_W){1'b0}}, cell_index} < blocks_in_use;
   assign eligible = srch_in.active && in_use && free_ff && (size_ff >= srch_in.req_size);
   assign wr_hit   = (wr_index == cell_index);

   // Policy decision for this entry
   always_comb begin
      case (srch_in.func)
         FUNC_FIRST: take = eligible && !srch_in.found;
         FUNC_BEST:  take = eligible && (!srch_in.found || size_ff < srch_in.pick_size);
         FUNC_WORST: take = eligible && (!srch_in.found || size_ff > srch_in.pick_size);
         default:    take = 1'b0;
      endcase
   end

   always_comb begin
      srch_in_n = srch_in;
      pick_in_n = pick_in;
      if (take) begin
         srch_in_n.found     = 1'b1;
         srch_in_n.pick_size = size_ff;
         pick_in_n           = cell_index;
      end
   end

   // Search record stage
   always_ff @(posedge clock) begin
      if (reset) begin
         srch_ff.active <= 1'b0;
      end else begin
         srch_ff.active <= srch_in_n.active;
      end
      srch_ff.found     <= srch_in_n.found;
      srch_ff.func      <= srch_in_n.func;
      srch_ff.req_size  <= srch_in_n.req_size;
      srch_ff.pick_size <= srch_in_n.pick_size;
      pick_ff           <= pick_in_n;
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (wr.load && wr_hit) begin
         size_ff  <= wr.size;
         free_ff  <= wr.free;
         owner_ff <= wr.owner;
      end else if (wr.claim && wr_hit) begin
         free_ff  <= 1'b0;
         owner_ff <= wr.owner;
      end
   end

   assign srch_out = srch_ff;
   assign pick_out = pick_ff;

endmodule

FILE: hdl/block_fit_allocator.sv
// Block fit allocator: ordered block table with first, best and worst fit.
// Usage:
//   Request channel (req_): tuser = func, tdata = block_length,
//   starts_free, process_id, request_size. One transfer per item.
//   Response channel (rsp_): tuser = outcome, tdata = block_index,
//   granted_size. Exactly one response per request.
// Sequencing:
//   An append item passes from the request transfer to the pending
//   result register and then to the response register; an allocation
//   first sends its search record along the row of MAX_BLOCKS table
//   cells, one cell per cycle, and its result is captured when the
//   record leaves the last cell. The next request is taken in the cycle
//   after the response is loaded. One item is in flight at a time.
// Reset clears the block count, so the table reads as empty; the entries
// themselves are not cleared. If the receiver stalls, the response holds
// in the output register, the next result waits in the controller, and
// the table is updated only when that result moves to the output.
// Depends on bfa_pkg and bfa_cell.
module block_fit_allocator #(
   parameter int MAX_BLOCKS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // block_length[15:0], starts_free[16],
                                   // process_id[32:17], request_size[48:33], zero
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // block_index[3:0], granted_size[19:4], zero
   output logic [1:0]  rsp_tuser   // outcome[1:0]
);
   import bfa_pkg::*;

   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_BLOCKS);

   // Request field unpacking
   logic [SIZE_W-1:0] in_blen;
   logic              in_free;
   logic [PID_W-1:0]  in_pid;
   logic [SIZE_W-1:0] in_req;
   func_type          in_func;

   assign in_blen = req_tdata[15:0];
   assign in_free = req_tdata[16];
   assign in_pid  = req_tdata[32:17];
   assign in_req  = req_tdata[48:33];
   assign in_func = func_type'(req_tuser);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]   rsp_out_ff;
   logic [IDX_W-1:0]   rsp_idx_ff;
   logic [SIZE_W-1:0]  rsp_size_ff;

   // Pending result and the table update it implies
   logic               pend_append_ff;
   logic [OUT_W-1:0]   pend_out_ff;
   logic [IDX_W-1:0]   pend_idx_ff;
   logic [SIZE_W-1:0]  pend_size_ff;
   logic               pend_free_ff;
   logic [PID_W-1:0]   pend_pid_ff;

   // Cell chain
   search_type         srch [0:MAX_BLOCKS];
   logic [IDX_W-1:0]   pick [0:MAX_BLOCKS];
   tbl_wr_type         wr;

   logic accept;
   logic launch;
   logic scan_done;
   logic out_free;
   logic commit;
   logic is_full;

   assign accept    = req_tvalid && req_tready;
   assign launch    = accept && (in_func != FUNC_APPEND);
   assign scan_done = srch[MAX_BLOCKS].active;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign is_full   = (cnt_ff == CNT_FULL);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (in_func == FUNC_APPEND) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Controller outputs
   always_comb begin
      req_tready = 1'b0;
      commit     = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_SCAN: req_tready = 1'b0;
         ST_DONE: commit     = out_free;
         default: req_tready = 1'b0;
      endcase
   end

   // Search record entering the first cell
   always_comb begin
      srch[0].active    = launch;
      srch[0].found     = 1'b0;
      srch[0].func      = in_func;
      srch[0].req_size  = in_req;
      srch[0].pick_size = '0;
      pick[0]           = '0;
   end

   // Table write on commit
   always_comb begin
      wr.load  = commit && pend_append_ff && (pend_out_ff == OUT_OK);
      wr.claim = commit && !pend_append_ff && (pend_out_ff == OUT_OK);
      wr.size  = pend_size_ff;
      wr.free  = pend_free_ff;
      wr.owner = (pend_append_ff && pend_free_ff) ? '0 : pend_pid_ff;
   end

   // Block count and response valid
   always_comb begin
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (wr.load) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Pending result capture
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_append_ff <= (in_func == FUNC_APPEND);
         pend_free_ff   <= in_free;
         pend_pid_ff    <= in_pid;
         if (in_func == FUNC_APPEND) begin
            pend_out_ff  <= is_full ? OUT_FULL : OUT_OK;
            pend_idx_ff  <= is_full ? '0 : cnt_ff[IDX_W-1:0];
            pend_size_ff <= is_full ? '0 : in_blen;
         end
      end else if (state_ff == ST_SCAN && scan_done) begin
         pend_out_ff  <= srch[MAX_BLOCKS].found ? OUT_OK : OUT_NOFIT;
         pend_idx_ff  <= srch[MAX_BLOCKS].found ? pick[MAX_BLOCKS] : '0;
         pend_size_ff <= srch[MAX_BLOCKS].found ? srch[MAX_BLOCKS].pick_size : '0;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_out_ff  <= pend_out_ff;
         rsp_idx_ff  <= pend_idx_ff;
         rsp_size_ff <= pend_size_ff;
      end
   end

   // Row of table cells
   for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
      bfa_cell #(
         .IDX_W (IDX_W),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cell_index    (IDX_W'(k)),
         .blocks_in_use (cnt_ff),
         .wr            (wr),
         .wr_index      (pend_idx_ff),
         .srch_in       (srch[k]),
         .pick_in       (pick[k]),
         .srch_out      (srch[k+1]),
         .pick_out      (pick[k+1])
      );
   end

   // Response packing
   logic [IDX_W+IDXO_W-1:0] idx_ext;

   assign idx_ext    = {{IDXO_W{1'b0}}, rsp_idx_ff};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_out_ff;
   assign rsp_tdata  = {4'b0, rsp_size_ff, idx_ext[IDXO_W-1:0]};

endmodule
